### rtl/first_fit_heap_allocator_defines.svh
// Assertion helpers included by ffha_checker.sv.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle while arst_n is low.
`define FFHA_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ffha_pkg.sv
package ffha_pkg;

	localparam int unsigned ARENA_MAX_BYTES = 65536;
	localparam int unsigned HEADER_BYTES    = 32;
	localparam int unsigned MIN_ARENA_BYTES = 1024;
	// headers only ever sit on four-byte boundaries
	localparam int unsigned GRAIN           = 4;
	localparam int unsigned DEPTH           = ARENA_MAX_BYTES / GRAIN;
	localparam int unsigned IDX_W           = $clog2(DEPTH);
	localparam int unsigned SIZE_W          = $clog2(ARENA_MAX_BYTES);
	// byte offsets carry two spare bits to catch running off the arena
	localparam int unsigned OFF_W           = SIZE_W + 2;
	localparam int unsigned MAX_STEPS       = ARENA_MAX_BYTES / HEADER_BYTES + 1;
	localparam int unsigned STEP_W          = $clog2(MAX_STEPS + 1);

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NOMEM    = 3'd1;
	localparam logic [2:0] ST_CORRUPT  = 3'd2;
	localparam logic [2:0] ST_DOUBLE   = 3'd3;
	localparam logic [2:0] ST_MISMATCH = 3'd4;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_INIT  = 2'd2;
	localparam logic [1:0] OP_CHECK = 2'd3;

	typedef logic [OFF_W-1:0] off_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic              valid;
		logic              used;
		logic              last;
		logic              has_before;
		logic [SIZE_W-1:0] size;
		logic [IDX_W-1:0]  prev;
	} hdr_t;

endpackage

### rtl/ffha_hdr_ram.sv
module ffha_hdr_ram (
	input  logic          clk,
	input  logic          we,
	input  ffha_pkg::idx_t waddr,
	input  ffha_pkg::hdr_t wdata,
	input  ffha_pkg::idx_t raddr,
	output ffha_pkg::hdr_t rdata
);

	ffha_pkg::hdr_t mem_q [ffha_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/first_fit_heap_allocator.sv
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------------------
// config   | cfg_wr_en                  | cfg_wr_data (arena_bytes)
// request  | in_valid / in_stall        | operation, request_bytes, data_address
// result   | out_valid / out_stall      | status, alloc_address, free/used bytes+chunks
//
// One transaction in flight; header reads come from a registered RAM. Alloc reads one header
// per chunk visited plus the one after a split; free reads the freed header, its neighbours
// and the chunk after a free follower; check reads one per chunk forwards, then backwards.
// Alloc, free and init then write one header a cycle (up to four); S_DONE posts the result.
// Reset and init clear all 16384 headers, one a cycle, with in_stall high.
// A result waits in the output register under out_stall; one more transaction may run.
module first_fit_heap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [16:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [16:0] request_bytes,
	input  logic [15:0] data_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] alloc_address,
	output logic [16:0] free_bytes,
	output logic [16:0] used_bytes,
	output logic [11:0] free_chunks,
	output logic [11:0] used_chunks
);

	localparam int unsigned OFF_W  = ffha_pkg::OFF_W;
	localparam int unsigned SIZE_W = ffha_pkg::SIZE_W;
	localparam int unsigned IDX_W  = ffha_pkg::IDX_W;
	localparam int unsigned STEP_W = ffha_pkg::STEP_W;

	// write-back slots, drained lowest first
	localparam logic [3:0] PEND_M   = 4'b0001; // kill of a merged header
	localparam logic [3:0] PEND_CUR = 4'b0010; // surviving chunk
	localparam logic [3:0] PEND_A   = 4'b0100; // split remainder / following chunk
	localparam logic [3:0] PEND_T   = 4'b1000; // back-link fix of the chunk after that

	typedef enum logic [3:0] {
		S_SWEEP, S_IDLE, S_AL_WALK, S_AL_T, S_FR_M, S_FR_A, S_FR_B, S_FR_AM, S_FR_T,
		S_CK_F, S_CK_B, S_COMMIT, S_DONE
	} state_t;

	state_t             state_q;
	ffha_pkg::off_t     off_q;      // offset whose header is on rd_hdr this cycle
	ffha_pkg::off_t     rd_off;
	ffha_pkg::hdr_t     rd_hdr;
	logic               we;
	ffha_pkg::idx_t     waddr;
	ffha_pkg::hdr_t     wdata;

	logic [16:0]        arena_q;
	logic [1:0]         op_q;
	ffha_pkg::off_t     need_q;
	logic [2:0]         st_q;
	logic [15:0]        res_addr_q;
	ffha_pkg::off_t     sum_q;
	logic [STEP_W-1:0]  steps_q;
	logic [16:0]        fb_q, ub_q;
	logic [11:0]        fc_q, uc_q;
	ffha_pkg::hdr_t     cur_q, a_q, t_q;
	ffha_pkg::off_t     cur_off_q, a_off_q, t_off_q, m_off_q;
	logic               has_after_q;
	logic [3:0]         pend_q;
	ffha_pkg::idx_t     sweep_idx_q;
	logic               sweep_init_q;

	logic               out_valid_q;
	logic [2:0]         status_q;
	logic [15:0]        alloc_address_q;
	logic [16:0]        free_bytes_q, used_bytes_q;
	logic [11:0]        free_chunks_q, used_chunks_q;

	logic               accept;
	logic               hdr_ok, fits, split;
	ffha_pkg::off_t     nxt_chain, need_in, other, a_next, sum_f, before_rd, before_cur;
	ffha_pkg::hdr_t     init_hdr, al_used, al_cut, al_other, fr_m, b_m, cur_m, t_upd;
	ffha_pkg::idx_t     t_target;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	// header lookup: inside the arena, on a four-byte boundary, marked valid
	assign hdr_ok    = (off_q[OFF_W-1:SIZE_W] == '0) && (off_q[1:0] == 2'b00) && rd_hdr.valid;
	assign nxt_chain = off_q + OFF_W'(ffha_pkg::HEADER_BYTES) + OFF_W'(rd_hdr.size);
	assign need_in   = (OFF_W'(request_bytes) + OFF_W'(3)) & ~OFF_W'(3);
	assign fits      = !rd_hdr.used && (OFF_W'(rd_hdr.size) >= need_q);
	assign split     = OFF_W'(rd_hdr.size) > (need_q + OFF_W'(ffha_pkg::HEADER_BYTES));
	assign other     = off_q + OFF_W'(ffha_pkg::HEADER_BYTES) + need_q;
	assign a_next    = a_off_q + OFF_W'(ffha_pkg::HEADER_BYTES) + OFF_W'(a_q.size);
	assign sum_f     = sum_q + OFF_W'(ffha_pkg::HEADER_BYTES) + OFF_W'(rd_hdr.size);
	assign before_rd  = OFF_W'({rd_hdr.prev, 2'b00});
	assign before_cur = OFF_W'({cur_q.prev, 2'b00});
	// a back-link fix points at the new remainder on alloc, at the survivor on free
	assign t_target  = (state_q == S_AL_T) ? a_off_q[IDX_W+1:2] : cur_off_q[IDX_W+1:2];

	always_comb begin
		init_hdr       = '0;
		init_hdr.valid = 1'b1;
		init_hdr.last  = 1'b1;
		init_hdr.size  = SIZE_W'(arena_q - 17'(ffha_pkg::HEADER_BYTES));

		al_used      = rd_hdr;
		al_used.used = 1'b1;

		al_cut      = al_used;
		al_cut.last = 1'b0;
		al_cut.size = SIZE_W'(need_q);

		al_other            = '0;
		al_other.valid      = 1'b1;
		al_other.last       = rd_hdr.last;
		al_other.has_before = 1'b1;
		al_other.prev       = off_q[IDX_W+1:2];
		al_other.size       = SIZE_W'(OFF_W'(rd_hdr.size) - need_q
			- OFF_W'(ffha_pkg::HEADER_BYTES));

		fr_m      = rd_hdr;
		fr_m.used = 1'b0;

		// previous chunk swallows the freed one and takes over its last flag
		b_m      = rd_hdr;
		b_m.size = rd_hdr.size + SIZE_W'(ffha_pkg::HEADER_BYTES) + cur_q.size;
		b_m.last = cur_q.last;

		// survivor swallows the following free chunk
		cur_m      = cur_q;
		cur_m.size = cur_q.size + SIZE_W'(ffha_pkg::HEADER_BYTES) + a_q.size;
		cur_m.used = a_q.used;
		cur_m.last = a_q.last;

		t_upd            = rd_hdr;
		t_upd.prev       = t_target;
		t_upd.has_before = 1'b1;
	end

	// read address for the header needed next cycle; default re-reads the same one
	always_comb begin
		rd_off = off_q;
		case (state_q)
			S_IDLE: begin
				if (accept && operation == ffha_pkg::OP_FREE) begin
					rd_off = OFF_W'(data_address) - OFF_W'(ffha_pkg::HEADER_BYTES);
				end else if (accept) begin
					rd_off = '0;
				end
			end
			S_AL_WALK: begin
				if (hdr_ok && !rd_hdr.last && (!fits || split)) begin
					rd_off = nxt_chain;
				end
			end
			S_FR_M: begin
				if (hdr_ok && rd_hdr.used && !rd_hdr.last) begin
					rd_off = nxt_chain;
				end else if (hdr_ok && rd_hdr.used && rd_hdr.has_before) begin
					rd_off = before_rd;
				end
			end
			S_FR_A: begin
				if (hdr_ok && cur_q.has_before) begin
					rd_off = before_cur;
				end
			end
			S_FR_AM: begin
				if (has_after_q && !a_q.used && !a_q.last) begin
					rd_off = a_next;
				end
			end
			S_CK_F: begin
				if (hdr_ok && !rd_hdr.last) begin
					rd_off = nxt_chain;
				end
			end
			S_CK_B: begin
				if (hdr_ok && rd_hdr.has_before) begin
					rd_off = before_rd;
				end
			end
			default: ;
		endcase
	end

	// write port: clear sweep, or drain one pending slot a cycle
	always_comb begin
		we    = 1'b0;
		waddr = sweep_idx_q;
		wdata = '0;
		case (state_q)
			S_SWEEP: begin
				we = 1'b1;
			end
			S_COMMIT: begin
				we = (pend_q != '0);
				if ((pend_q & PEND_M) != '0) begin
					waddr = m_off_q[IDX_W+1:2];
				end else if ((pend_q & PEND_CUR) != '0) begin
					waddr = cur_off_q[IDX_W+1:2];
					wdata = cur_q;
				end else if ((pend_q & PEND_A) != '0) begin
					waddr = a_off_q[IDX_W+1:2];
					wdata = a_q;
				end else begin
					waddr = t_off_q[IDX_W+1:2];
					wdata = t_q;
				end
			end
			default: ;
		endcase
	end

	ffha_hdr_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_off[IDX_W+1:2]),
		.rdata (rd_hdr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			sweep_idx_q  <= '0;
			sweep_init_q <= 1'b0;
			arena_q      <= 17'(ffha_pkg::ARENA_MAX_BYTES);
			pend_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			off_q <= rd_off;
			if (cfg_wr_en) begin
				arena_q <= cfg_wr_data;
			end
			// drop the result once taken, unless the next one replaces it below
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_SWEEP: begin
					sweep_idx_q <= sweep_idx_q + 1'b1;
					if (sweep_idx_q == '1) begin
						if (sweep_init_q) begin
							// lay down the single free chunk at offset zero
							cur_q     <= init_hdr;
							cur_off_q <= '0;
							pend_q    <= PEND_CUR;
							st_q      <= ffha_pkg::ST_OK;
							state_q   <= S_COMMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q        <= operation;
						need_q      <= need_in;
						pend_q      <= '0;
						has_after_q <= 1'b0;
						sum_q       <= '0;
						steps_q     <= '0;
						fb_q        <= '0;
						ub_q        <= '0;
						fc_q        <= '0;
						uc_q        <= '0;
						res_addr_q  <= '0;
						case (operation)
							ffha_pkg::OP_ALLOC: state_q <= S_AL_WALK;
							ffha_pkg::OP_FREE: begin
								if (data_address < 16'(ffha_pkg::HEADER_BYTES)) begin
									st_q    <= ffha_pkg::ST_CORRUPT;
									state_q <= S_DONE;
								end else begin
									state_q <= S_FR_M;
								end
							end
							ffha_pkg::OP_INIT: begin
								if (arena_q < 17'(ffha_pkg::MIN_ARENA_BYTES) ||
								    arena_q > 17'(ffha_pkg::ARENA_MAX_BYTES)) begin
									st_q    <= ffha_pkg::ST_NOMEM;
									state_q <= S_DONE;
								end else begin
									sweep_init_q <= 1'b1;
									sweep_idx_q  <= '0;
									state_q      <= S_SWEEP;
								end
							end
							default: state_q <= S_CK_F;
						endcase
					end
				end
				S_AL_WALK: begin
					if (!hdr_ok) begin
						st_q    <= ffha_pkg::ST_CORRUPT;
						state_q <= S_DONE;
					end else if (!fits) begin
						if (rd_hdr.last) begin
							st_q    <= ffha_pkg::ST_NOMEM;
							state_q <= S_DONE;
						end
					end else begin
						cur_off_q  <= off_q;
						res_addr_q <= 16'(off_q + OFF_W'(ffha_pkg::HEADER_BYTES));
						if (!split) begin
							cur_q   <= al_used;
							pend_q  <= PEND_CUR;
							st_q    <= ffha_pkg::ST_OK;
							state_q <= S_COMMIT;
						end else if (other[OFF_W-1:SIZE_W] != '0) begin
							st_q    <= ffha_pkg::ST_CORRUPT;
							state_q <= S_DONE;
						end else begin
							a_q     <= al_other;
							a_off_q <= other;
							if (rd_hdr.last) begin
								cur_q   <= al_cut;
								pend_q  <= PEND_CUR | PEND_A;
								st_q    <= ffha_pkg::ST_OK;
								state_q <= S_COMMIT;
							end else begin
								// hold the used mark alone until the next header checks out
								cur_q   <= al_used;
								state_q <= S_AL_T;
							end
						end
					end
				end
				S_AL_T: begin
					if (!hdr_ok) begin
						pend_q  <= PEND_CUR;
						st_q    <= ffha_pkg::ST_CORRUPT;
						state_q <= S_COMMIT;
					end else begin
						cur_q.size <= SIZE_W'(need_q);
						t_q        <= t_upd;
						t_off_q    <= off_q;
						pend_q     <= PEND_CUR | PEND_A | PEND_T;
						st_q       <= ffha_pkg::ST_OK;
						state_q    <= S_COMMIT;
					end
				end
				S_FR_M: begin
					if (!hdr_ok) begin
						st_q    <= ffha_pkg::ST_CORRUPT;
						state_q <= S_DONE;
					end else if (!rd_hdr.used) begin
						st_q    <= ffha_pkg::ST_DOUBLE;
						state_q <= S_DONE;
					end else begin
						cur_q     <= fr_m;
						cur_off_q <= off_q;
						m_off_q   <= off_q;
						pend_q    <= PEND_CUR;
						if (!rd_hdr.last) begin
							state_q <= S_FR_A;
						end else if (rd_hdr.has_before) begin
							state_q <= S_FR_B;
						end else begin
							st_q    <= ffha_pkg::ST_OK;
							state_q <= S_COMMIT;
						end
					end
				end
				S_FR_A: begin
					if (!hdr_ok) begin
						st_q    <= ffha_pkg::ST_CORRUPT;
						state_q <= S_COMMIT;
					end else begin
						a_q         <= rd_hdr;
						a_off_q     <= off_q;
						has_after_q <= 1'b1;
						state_q     <= cur_q.has_before ? S_FR_B : S_FR_AM;
					end
				end
				S_FR_B: begin
					if (!hdr_ok) begin
						st_q    <= ffha_pkg::ST_CORRUPT;
						state_q <= S_COMMIT;
					end else begin
						if (!rd_hdr.used) begin
							cur_q     <= b_m;
							cur_off_q <= off_q;
							if (has_after_q) begin
								a_q.prev       <= off_q[IDX_W+1:2];
								a_q.has_before <= 1'b1;
								pend_q         <= pend_q | PEND_M | PEND_A;
							end else begin
								pend_q <= pend_q | PEND_M;
							end
						end
						state_q <= S_FR_AM;
					end
				end
				S_FR_AM: begin
					if (has_after_q && !a_q.used) begin
						if (!a_q.last) begin
							state_q <= S_FR_T;
						end else begin
							cur_q   <= cur_m;
							a_q     <= '0;
							pend_q  <= pend_q | PEND_A;
							st_q    <= ffha_pkg::ST_OK;
							state_q <= S_COMMIT;
						end
					end else begin
						st_q    <= ffha_pkg::ST_OK;
						state_q <= S_COMMIT;
					end
				end
				S_FR_T: begin
					if (!hdr_ok) begin
						st_q    <= ffha_pkg::ST_CORRUPT;
						state_q <= S_COMMIT;
					end else begin
						t_q     <= t_upd;
						t_off_q <= off_q;
						cur_q   <= cur_m;
						a_q     <= '0;
						pend_q  <= pend_q | PEND_A | PEND_T;
						st_q    <= ffha_pkg::ST_OK;
						state_q <= S_COMMIT;
					end
				end
				S_CK_F: begin
					if (!hdr_ok) begin
						st_q    <= ffha_pkg::ST_CORRUPT;
						state_q <= S_DONE;
					end else begin
						sum_q <= sum_f;
						if (rd_hdr.used) begin
							ub_q <= ub_q + 17'(rd_hdr.size);
							if (uc_q != '1) begin
								uc_q <= uc_q + 1'b1;
							end
						end else begin
							fb_q <= fb_q + 17'(rd_hdr.size);
							if (fc_q != '1) begin
								fc_q <= fc_q + 1'b1;
							end
						end
						if (rd_hdr.last) begin
							if (sum_f != OFF_W'(arena_q)) begin
								st_q    <= ffha_pkg::ST_MISMATCH;
								state_q <= S_DONE;
							end else begin
								// re-read the last header and walk back
								sum_q   <= '0;
								steps_q <= '0;
								state_q <= S_CK_B;
							end
						end
					end
				end
				S_CK_B: begin
					if (!hdr_ok) begin
						st_q    <= ffha_pkg::ST_CORRUPT;
						state_q <= S_DONE;
					end else begin
						sum_q <= sum_f;
						if (!rd_hdr.has_before) begin
							st_q    <= (sum_f != OFF_W'(arena_q)) ? ffha_pkg::ST_MISMATCH
								: ffha_pkg::ST_OK;
							state_q <= S_DONE;
						end else if (steps_q >= STEP_W'(ffha_pkg::MAX_STEPS)) begin
							// back links loop
							st_q    <= ffha_pkg::ST_CORRUPT;
							state_q <= S_DONE;
						end else begin
							steps_q <= steps_q + 1'b1;
						end
					end
				end
				S_COMMIT: begin
					if ((pend_q & PEND_M) != '0) begin
						pend_q <= pend_q & ~PEND_M;
					end else if ((pend_q & PEND_CUR) != '0) begin
						pend_q <= pend_q & ~PEND_CUR;
					end else if ((pend_q & PEND_A) != '0) begin
						pend_q <= pend_q & ~PEND_A;
					end else if ((pend_q & PEND_T) != '0) begin
						pend_q <= pend_q & ~PEND_T;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q     <= 1'b1;
						status_q        <= st_q;
						alloc_address_q <= (op_q == ffha_pkg::OP_ALLOC && st_q == ffha_pkg::ST_OK)
							? res_addr_q : '0;
						if (op_q == ffha_pkg::OP_CHECK && st_q == ffha_pkg::ST_OK) begin
							free_bytes_q  <= fb_q;
							used_bytes_q  <= ub_q;
							free_chunks_q <= fc_q;
							used_chunks_q <= uc_q;
						end else begin
							free_bytes_q  <= '0;
							used_bytes_q  <= '0;
							free_chunks_q <= '0;
							used_chunks_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign alloc_address = alloc_address_q;
	assign free_bytes    = free_bytes_q;
	assign used_bytes    = used_bytes_q;
	assign free_chunks   = free_chunks_q;
	assign used_chunks   = used_chunks_q;

endmodule

### rtl/ffha_checker.sv
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [15:0] alloc_address,
	input logic [16:0] free_bytes,
	input logic [16:0] used_bytes,
	input logic [11:0] free_chunks,
	input logic [11:0] used_chunks
);

	`FFHA_ASSERT_IMPLY(a_status_range, out_valid, status <= ffha_pkg::ST_MISMATCH, "status code out of range")
	`FFHA_ASSERT_IMPLY(a_err_zero, out_valid && status != ffha_pkg::ST_OK, alloc_address == '0 && free_bytes == '0 && used_bytes == '0 && free_chunks == '0 && used_chunks == '0, "error result carries data")
	`FFHA_ASSERT_IMPLY(a_counts, out_valid && free_chunks == '0 && used_chunks == '0, free_bytes == '0 && used_bytes == '0, "bytes reported without chunks")
	`FFHA_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second request taken while one is in flight")
	`FFHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status), "stalled result changed")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

### dv/first_fit_heap_allocator_checker.sv
`timescale 1ns / 1ps

module first_fit_heap_allocator_checker
	import ffha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [16:0] cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [16:0] request_bytes,
	input  logic [15:0] data_address,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [15:0] alloc_address,
	input  logic [16:0] free_bytes,
	input  logic [16:0] used_bytes,
	input  logic [11:0] free_chunks,
	input  logic [11:0] used_chunks,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		bit          valid;
		bit          used;
		bit          last;
		bit          has_before;
		int unsigned size;
		int unsigned prev;
	} chunk_t;

	typedef struct {
		logic [2:0]  status;
		logic [15:0] addr;
		logic [16:0] fb;
		logic [16:0] ub;
		logic [11:0] fc;
		logic [11:0] uc;
	} outcome_t;

	chunk_t      heap[int unsigned];
	int unsigned arena_size;
	outcome_t    outcome_q[$];

	function automatic bit chunk_present(int unsigned off);
		return off < ARENA_MAX_BYTES && heap.exists(off) && heap[off].valid;
	endfunction

	function automatic int unsigned chunk_next(int unsigned off);
		return off + HEADER_BYTES + heap[off].size;
	endfunction

	function automatic logic [2:0] alloc_predict(int unsigned req, output int unsigned addr);
		int unsigned need;
		int unsigned off;
		int unsigned other;
		int unsigned t;
		bit          olast;
		need = (req + 3) & ~32'd3;
		off = 0;
		addr = 0;
		while (1'b1) begin
			if (!chunk_present(off))
				return ST_CORRUPT;
			if (heap[off].used || heap[off].size < need) begin
				if (heap[off].last)
					return ST_NOMEM;
				off = chunk_next(off);
			end else begin
				break;
			end
		end
		if (heap[off].size > need + HEADER_BYTES) begin
			other = off + HEADER_BYTES + need;
			if (other >= ARENA_MAX_BYTES)
				return ST_CORRUPT;
			heap[off].used = 1;
			if (heap[off].last) begin
				olast = 1;
				heap[off].last = 0;
			end else begin
				t = chunk_next(off);
				olast = 0;
				if (!chunk_present(t))
					return ST_CORRUPT;
				heap[t].prev = other;
				heap[t].has_before = 1;
			end
			heap[other].valid = 1;
			heap[other].used = 0;
			heap[other].last = olast;
			heap[other].has_before = 1;
			heap[other].prev = off;
			heap[other].size = heap[off].size - need - HEADER_BYTES;
			heap[off].size = need;
		end else begin
			heap[off].used = 1;
		end
		addr = off + HEADER_BYTES;
		return ST_OK;
	endfunction

	function automatic logic [2:0] free_predict(int unsigned addr);
		int unsigned m;
		int unsigned a;
		int unsigned b;
		int unsigned t;
		bit          has_after;
		a = 0;
		has_after = 0;
		if (addr < HEADER_BYTES)
			return ST_CORRUPT;
		m = addr - HEADER_BYTES;
		if (!chunk_present(m))
			return ST_CORRUPT;
		if (!heap[m].used)
			return ST_DOUBLE;
		heap[m].used = 0;
		if (!heap[m].last) begin
			a = chunk_next(m);
			if (!chunk_present(a))
				return ST_CORRUPT;
			has_after = 1;
		end
		if (heap[m].has_before) begin
			b = heap[m].prev;
			if (!chunk_present(b))
				return ST_CORRUPT;
			if (!heap[b].used) begin
				heap[b].size += HEADER_BYTES + heap[m].size;
				heap[b].last = heap[m].last;
				if (has_after) begin
					heap[a].prev = b;
					heap[a].has_before = 1;
				end
				heap.delete(m);
				m = b;
			end
		end
		if (has_after && !heap[a].used) begin
			if (!heap[a].last) begin
				t = chunk_next(a);
				if (!chunk_present(t))
					return ST_CORRUPT;
				heap[t].prev = m;
				heap[t].has_before = 1;
			end
			heap[m].size += HEADER_BYTES + heap[a].size;
			heap[m].used = heap[a].used;
			heap[m].last = heap[a].last;
			heap.delete(a);
		end
		return ST_OK;
	endfunction

	function automatic logic [2:0] init_predict();
		chunk_t c;
		if (arena_size < MIN_ARENA_BYTES || arena_size > ARENA_MAX_BYTES)
			return ST_NOMEM;
		heap.delete();
		c = '{1, 0, 1, 0, arena_size - HEADER_BYTES, 0};
		heap[0] = c;
		return ST_OK;
	endfunction

	function automatic void check_predict(ref outcome_t res);
		longint      sum;
		longint      fb;
		longint      ub;
		longint      fc;
		longint      uc;
		longint      steps;
		int unsigned off;
		sum = 0; fb = 0; ub = 0; fc = 0; uc = 0; steps = 0;
		off = 0;
		while (1'b1) begin
			if (!chunk_present(off)) begin
				res.status = ST_CORRUPT;
				return;
			end
			sum += HEADER_BYTES + heap[off].size;
			if (heap[off].used) begin
				ub += heap[off].size;
				uc++;
			end else begin
				fb += heap[off].size;
				fc++;
			end
			if (heap[off].last)
				break;
			off = chunk_next(off);
		end
		if (sum != arena_size) begin
			res.status = ST_MISMATCH;
			return;
		end
		// walk back from the last chunk along the back links
		sum = 0;
		while (1'b1) begin
			if (!chunk_present(off)) begin
				res.status = ST_CORRUPT;
				return;
			end
			sum += HEADER_BYTES + heap[off].size;
			if (!heap[off].has_before)
				break;
			off = heap[off].prev;
			steps++;
			if (steps > MAX_STEPS) begin
				res.status = ST_CORRUPT;
				return;
			end
		end
		if (sum != arena_size) begin
			res.status = ST_MISMATCH;
			return;
		end
		res.status = ST_OK;
		res.fb = fb[16:0];
		res.ub = ub[16:0];
		res.fc = (fc > 4095) ? 12'd4095 : fc[11:0];
		res.uc = (uc > 4095) ? 12'd4095 : uc[11:0];
	endfunction

	function automatic outcome_t predict_result(logic [1:0] op, logic [16:0] req,
		logic [15:0] addr);
		outcome_t    res;
		int unsigned got;
		res = '{ST_OK, 16'd0, 17'd0, 17'd0, 12'd0, 12'd0};
		case (op)
			OP_ALLOC: begin
				res.status = alloc_predict(req, got);
				if (res.status == ST_OK)
					res.addr = got[15:0];
			end
			OP_FREE:  res.status = free_predict(addr);
			OP_INIT:  res.status = init_predict();
			default:  check_predict(res);
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t exp_res;
		if (!arst_n) begin
			heap.delete();
			arena_size = 65536;
			outcome_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// results are compared before this edge's request updates the heap
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: status %0d addr %0d", status,
							alloc_address);
				end else begin
					exp_res = outcome_q.pop_front();
					pending--;
					if (status !== exp_res.status || alloc_address !== exp_res.addr ||
						free_bytes !== exp_res.fb || used_bytes !== exp_res.ub ||
						free_chunks !== exp_res.fc || used_chunks !== exp_res.uc) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: exp st %0d addr %0d fb %0d ub %0d fc %0d",
								" uc %0d / got st %0d addr %0d fb %0d ub %0d fc %0d uc %0d"},
								exp_res.status, exp_res.addr, exp_res.fb, exp_res.ub,
								exp_res.fc, exp_res.uc, status, alloc_address, free_bytes,
								used_bytes, free_chunks, used_chunks);
					end
				end
			end
			if (in_valid && !in_stall) begin
				outcome_q.push_back(predict_result(operation, request_bytes, data_address));
				pending++;
			end
			if (cfg_wr_en)
				arena_size = cfg_wr_data;
		end
	end

endmodule

### dv/first_fit_heap_allocator_tb.sv
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;
	import ffha_pkg::*;

	// cycles without any transaction before the run is declared hung; covers the
	// header clear after reset or init plus the longest chain walk, many times over
	localparam int HANG_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [16:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [16:0] request_bytes;
	logic [15:0] data_address;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [15:0] alloc_address;
	logic [16:0] free_bytes;
	logic [16:0] used_bytes;
	logic [11:0] free_chunks;
	logic [11:0] used_chunks;

	int          fail_count;
	int          pending;

	int          send_idle_pct;
	int          recv_stall_pct;
	bit          hold_req;
	int          hold_left;
	int          quiet_cycles;
	int          op_count[4];
	logic [15:0] live_addrs[$];
	logic [15:0] freed_addrs[$];

	first_fit_heap_allocator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.request_bytes (request_bytes),
		.data_address  (data_address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.alloc_address (alloc_address),
		.free_bytes    (free_bytes),
		.used_bytes    (used_bytes),
		.free_chunks   (free_chunks),
		.used_chunks   (used_chunks)
	);

	first_fit_heap_allocator_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.request_bytes (request_bytes),
		.data_address  (data_address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.alloc_address (alloc_address),
		.free_bytes    (free_bytes),
		.used_bytes    (used_bytes),
		.free_chunks   (free_chunks),
		.used_chunks   (used_chunks),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always #5 clk = ~clk;

	// Drive the result stall: a long hold-off when requested, else random stalls.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 400;
			out_stall = 1'b1;
		end else begin
			out_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Record granted payload addresses so frees can target live chunks.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall && status == ST_OK && alloc_address != 0)
			live_addrs.push_back(alloc_address);
	end

	// Watchdog: abort when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", pending);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Offer one transaction and hold it until accepted; return at the next falling edge.
	task automatic send_item(logic [1:0] op, logic [16:0] req, logic [15:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		request_bytes = req;
		data_address = addr;
		op_count[op]++;
		if (op == OP_INIT)
			live_addrs.delete();
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering and wait until every predicted result has been handed over.
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_arena(logic [16:0] bytes);
		cfg_wr_en = 1'b1;
		cfg_wr_data = bytes;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	function automatic logic [16:0] pick_request();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return 17'($urandom_range(256));
		if (r < 95)
			return 17'($urandom_range(4096));
		return (r < 98) ? 17'd65536 : 17'($urandom_range(65536));
	endfunction

	function automatic logic [15:0] pick_free_address();
		int r;
		int k;
		logic [15:0] a;
		r = $urandom_range(99);
		if (r < 75 && live_addrs.size() > 0) begin
			k = $urandom_range(live_addrs.size() - 1);
			a = live_addrs[k];
			live_addrs.delete(k);
			freed_addrs.push_back(a);
			if (freed_addrs.size() > 8)
				void'(freed_addrs.pop_front());
			return a;
		end
		// hit a recently released chunk again: double free or stale header
		if (r < 85 && freed_addrs.size() > 0)
			return freed_addrs[$urandom_range(freed_addrs.size() - 1)];
		return 16'($urandom);
	endfunction

	// Random mix: mostly allocs and frees of live chunks, some checks, rare re-inits.
	task automatic random_items(int count);
		int r;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 45)
				send_item(OP_ALLOC, pick_request(), 16'($urandom));
			else if (r < 85)
				send_item(OP_FREE, 17'($urandom), pick_free_address());
			else if (r < 97)
				send_item(OP_CHECK, 17'($urandom), 16'($urandom));
			else
				send_item(OP_INIT, 17'($urandom), 16'($urandom));
		end
	endtask

	task automatic random_phase(logic [16:0] bytes, int idle_pct, int stall_pct, int count);
		drain();
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		write_arena(bytes);
		send_item(OP_INIT, 17'd0, 16'd0);
		random_items(count);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		operation = OP_ALLOC;
		request_bytes = '0;
		data_address = '0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: nothing is formatted yet, so every walk hits a missing header.
		send_item(OP_CHECK, 17'd0, 16'd0);
		send_item(OP_ALLOC, 17'd0, 16'd0);
		send_item(OP_FREE, 17'd0, 16'd32);
		drain();
		// Init with arena sizes just below the minimum and above the maximum.
		write_arena(17'd1023);
		send_item(OP_INIT, 17'd0, 16'd0);
		drain();
		write_arena(17'h1FFFF);
		send_item(OP_INIT, 17'd0, 16'd0);
		drain();
		// Smallest arena: split, free with merges on both sides, bad frees.
		write_arena(17'd1024);
		send_item(OP_INIT, 17'd0, 16'd0);
		send_item(OP_ALLOC, 17'd0, 16'd0);
		send_item(OP_ALLOC, 17'd1, 16'd0);
		send_item(OP_ALLOC, 17'd8, 16'd0);
		send_item(OP_CHECK, 17'd0, 16'd0);
		send_item(OP_FREE, 17'd0, 16'd64);
		send_item(OP_FREE, 17'd0, 16'd32);
		send_item(OP_FREE, 17'd0, 16'd100);
		send_item(OP_FREE, 17'd0, 16'd100);
		send_item(OP_FREE, 17'd0, 16'd32);
		send_item(OP_FREE, 17'd0, 16'd16);
		send_item(OP_FREE, 17'd0, 16'd33);
		send_item(OP_ALLOC, 17'd992, 16'd0);
		send_item(OP_ALLOC, 17'd1, 16'd0);
		send_item(OP_ALLOC, 17'd65536, 16'hFFFF);
		send_item(OP_CHECK, 17'd0, 16'd0);
		drain();
		// Arena size changed behind init's back: check reports the size gap.
		write_arena(17'd2048);
		send_item(OP_CHECK, 17'd0, 16'd0);
		drain();
		// Zero size: init refuses and leaves the formatted arena in place.
		write_arena(17'd0);
		send_item(OP_INIT, 17'd0, 16'd0);
		send_item(OP_FREE, 17'd0, 16'd32);
		drain();
		write_arena(17'd65536);
		send_item(OP_INIT, 17'd0, 16'd0);
		send_item(OP_ALLOC, 17'd65504, 16'd0);
		send_item(OP_CHECK, 17'd0, 16'd0);
		send_item(OP_FREE, 17'd0, 16'd32);

		// Random phases across arena sizes and flow-control patterns.
		random_phase(17'd65536, 0, 0, 65);
		random_phase(17'd1024, 72, 0, 30);
		// Pause until every result is back, then carry on.
		drain();
		random_items(30);
		random_phase(17'd4096, 0, 72, 30);
		// Hold the result side off while requests keep coming and back up.
		hold_req = 1'b1;
		random_items(12);
		random_items(20);
		random_phase(17'($urandom_range(1024, 65536)), 16, 16, 65);

		drain();
		repeat (20) @(negedge clk);
		$display("ran %0d allocs, %0d frees, %0d inits, %0d checks over four arena sizes",
			op_count[OP_ALLOC], op_count[OP_FREE], op_count[OP_INIT], op_count[OP_CHECK]);
		$display("flow control: free running, sender gaps, result stalls, both, long hold");
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d failures, %0d results outstanding", fail_count, pending);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_hdr_ram.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_checker.sv
dv/first_fit_heap_allocator_checker.sv
dv/first_fit_heap_allocator_tb.sv
